### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the circular fifo buffer rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is asserted
`define AST_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define AST_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/cfb_pkg.sv
// ---------------------------------------------------------------------------
// cfb_pkg
// shared types, codes and widths of the circular fifo buffer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cfb_pkg;

    // built depth of the storage
    localparam int DEPTH_DEF = 256;

    // fixed field widths
    localparam int CAP_W       = 9;
    localparam int CAP_MAX     = (1 << CAP_W) - 1;
    localparam int DATA_W      = 32;
    localparam int ACT_W       = 2;
    localparam int RESULT_BITS = 1 + DATA_W + CAP_W + CAP_W + 1 + 1;
    localparam int M_TDATA_W   = ((RESULT_BITS + 7) / 8) * 8;

    // operation codes carried on the input tuser
    typedef enum logic [ACT_W-1:0] {
        ACT_PUT  = 2'd0,
        ACT_GET  = 2'd1,
        ACT_PEEK = 2'd2
    } cfb_act_t;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } cfb_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic cfg_load;
        logic capture;
        logic execute;
    } cfb_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } cfb_stat_t;

endpackage

`default_nettype wire

### sv/cfb_ram.sv
// ---------------------------------------------------------------------------
// cfb_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### sv/cfb_ctrl.sv
// ---------------------------------------------------------------------------
// cfb_ctrl
// sequencing state machine: accepts a request or a capacity write; a
// request then waits for the result slot before committing the operation
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfb_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    input  wire logic              cfg_valid,
    input  wire cfb_pkg::cfb_stat_t stat,
    output cfb_pkg::cfb_cmd_t      cmd,
    output logic                   s_tready,
    output logic                   cfg_ready
);

    import cfb_pkg::*;

    cfb_state_t state_reg;
    cfb_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands, capacity write wins over a request
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        cfg_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cfg_ready    = 1'b1;
                s_tready     = !cfg_valid;
                cmd.cfg_load = cfg_valid;
                cmd.capture  = s_tvalid && !cfg_valid;
                if (s_tvalid && !cfg_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.execute = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/cfb_dpath.sv
// ---------------------------------------------------------------------------
// cfb_dpath
// fifo datapath: storage ram, pointers, full flag, fill count, capacity
// register and the result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cfb_dpath #(
    parameter int DEPTH = cfb_pkg::DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cfb_pkg::cfb_cmd_t             cmd,
    output cfb_pkg::cfb_stat_t                 stat,
    input  wire logic [cfb_pkg::ACT_W-1:0]     s_tuser,
    input  wire logic [cfb_pkg::DATA_W-1:0]    s_tdata,
    input  wire logic [cfb_pkg::CAP_W-1:0]     cfg_data,
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    output logic [cfb_pkg::M_TDATA_W-1:0]      m_tdata
);

    import cfb_pkg::*;

    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CMP_W     = (PTR_W + 1 > CAP_W) ? PTR_W + 1 : CAP_W;
    localparam int CAP_RESET = (DEPTH > CAP_MAX) ? CAP_MAX : DEPTH;

    // request registers
    logic [ACT_W-1:0]  act_reg;
    logic [DATA_W-1:0] wval_reg;

    // fifo state
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic             full_reg, full_next;
    logic [CAP_W-1:0] fill_reg, fill_next;
    logic [CAP_W-1:0] cap_reg, cap_next;

    // result registers
    logic              out_valid_reg, out_valid_next;
    logic              ok_reg;
    logic [DATA_W-1:0] rv_reg;
    logic [CAP_W-1:0]  fill_out_reg;
    logic [CAP_W-1:0]  free_out_reg;
    logic              empty_out_reg;
    logic              full_out_reg;

    logic [DATA_W-1:0] ram_rd_data;
    logic [PTR_W-1:0]  wp_inc, rp_inc;
    logic              put_ok, rd_ok, get_ok;
    logic [CAP_W-1:0]  cap_clamp;

    // pointer advance with wrap at the capacity
    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p,
                                                  input logic [CAP_W-1:0] c);
        logic [CMP_W-1:0] n;
        n = CMP_W'(p) + CMP_W'(1);
        wrap_inc = (n >= CMP_W'(c)) ? '0 : n[PTR_W-1:0];
    endfunction

    // storage, read port always follows the read pointer
    cfb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.execute && put_ok),
        .wr_addr (wp_reg),
        .wr_data (wval_reg),
        .rd_addr (rp_reg),
        .rd_data (ram_rd_data)
    );

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg  <= s_tuser;
            wval_reg <= s_tdata;
        end
    end

    // operation decode
    always_comb
    begin
        put_ok = 1'b0;
        rd_ok  = 1'b0;
        get_ok = 1'b0;
        case (act_reg)
            ACT_PUT:
            begin
                put_ok = !full_reg;
            end
            ACT_GET:
            begin
                rd_ok  = (fill_reg != '0);
                get_ok = (fill_reg != '0);
            end
            ACT_PEEK:
            begin
                rd_ok = (fill_reg != '0);
            end
            default:
            begin
                put_ok = 1'b0;
            end
        endcase
    end

    assign wp_inc = wrap_inc(wp_reg, cap_reg);
    assign rp_inc = wrap_inc(rp_reg, cap_reg);

    // capacity write clamped to one up to the built depth
    always_comb
    begin
        if (cfg_data == '0)
        begin
            cap_clamp = CAP_W'(1);
        end
        else if (CMP_W'(cfg_data) > CMP_W'(DEPTH))
        begin
            cap_clamp = CAP_W'(DEPTH);
        end
        else
        begin
            cap_clamp = cfg_data;
        end
    end

    // next fifo state
    always_comb
    begin
        wp_next   = wp_reg;
        rp_next   = rp_reg;
        full_next = full_reg;
        fill_next = fill_reg;
        cap_next  = cap_reg;
        if (cmd.cfg_load)
        begin
            if (fill_reg == '0)
            begin
                cap_next  = cap_clamp;
                wp_next   = '0;
                rp_next   = '0;
                full_next = 1'b0;
            end
        end
        else if (cmd.execute)
        begin
            if (put_ok)
            begin
                wp_next   = wp_inc;
                full_next = (wp_inc == rp_reg);
                fill_next = fill_reg + CAP_W'(1);
            end
            else if (get_ok)
            begin
                rp_next   = rp_inc;
                full_next = 1'b0;
                fill_next = fill_reg - CAP_W'(1);
            end
        end
    end

    // fifo state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            full_reg <= 1'b0;
            fill_reg <= '0;
            cap_reg  <= CAP_W'(CAP_RESET);
        end
        else
        begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            full_reg <= full_next;
            fill_reg <= fill_next;
            cap_reg  <= cap_next;
        end
    end

    // result slot occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.execute)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, status taken after the step
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            ok_reg        <= put_ok || rd_ok;
            rv_reg        <= rd_ok ? ram_rd_data : '0;
            fill_out_reg  <= fill_next;
            free_out_reg  <= cap_reg - fill_next;
            empty_out_reg <= (fill_next == '0);
            full_out_reg  <= full_next;
        end
    end

    assign stat.out_free = !out_valid_reg || m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = M_TDATA_W'({full_out_reg, empty_out_reg, free_out_reg,
                                       fill_out_reg, rv_reg, ok_reg});

    // consistency of the count, flag and pointers
    `AST_CLK(a_fill_le_cap, fill_reg <= cap_reg, "fill count above capacity")
    `AST_CLK(a_full_means_cap, full_reg |-> (fill_reg == cap_reg), "full flag without full count")
    `AST_CLK(a_empty_ptrs, (fill_reg == '0) |-> ((wp_reg == rp_reg) && !full_reg),
             "empty fifo with pointers apart")
    `AST_CLK(a_exec_fills_slot, cmd.execute |=> out_valid_reg, "result lost after execute")

endmodule

`default_nettype wire

### sv/circular_fifo_buffer.sv
// ---------------------------------------------------------------------------
// circular_fifo_buffer
// ring-buffer fifo of signed 32-bit words with a run-time capacity register
// ---------------------------------------------------------------------------
//  channel   dir  handshake                payload
//  s_*       in   s_tvalid / s_tready      tuser action, tdata write_value
//  m_*       out  m_tvalid / m_tready      tdata ok .. is_full
//  cfg_*     in   cfg_valid / cfg_ready    cfg_data capacity
//
//  on a request's accept edge the storage ram's registered read port also
//  loads at the read pointer; once the result slot is free, the exec state
//  commits the step and loads the result register.
//  a capacity write is taken only between requests.
//  a stalled result holds the controller until the result slot frees up.
//  after reset the fifo is empty, capacity equals the built depth, no
//  clearing pass is needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module circular_fifo_buffer #(
    parameter int DEPTH = cfb_pkg::DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request channel
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [cfb_pkg::DATA_W-1:0]    s_tdata,   // [31:0] write_value
    input  wire logic [cfb_pkg::ACT_W-1:0]     s_tuser,   // [1:0] action
    // result channel
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [0] ok, [32:1] read_value, [41:33] fill_count, [50:42] free_count,
    // [51] is_empty, [52] is_full, [55:53] zero
    output logic [cfb_pkg::M_TDATA_W-1:0]      m_tdata,
    // capacity write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [cfb_pkg::CAP_W-1:0]     cfg_data
);

    import cfb_pkg::*;

    cfb_cmd_t  cmd;
    cfb_stat_t stat;

    // sequencing
    cfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .cfg_valid (cfg_valid),
        .stat      (stat),
        .cmd       (cmd),
        .s_tready  (s_tready),
        .cfg_ready (cfg_ready)
    );

    // storage and status
    cfb_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .cfg_data (cfg_data),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

    // one request in flight, and it always yields a result
    `AST_CLK(a_one_in_flight, (s_tvalid && s_tready) |=> !s_tready, "second request taken early")
    `AST_CLK(a_no_cfg_with_req, (s_tvalid && s_tready) |-> !cfg_valid,
             "request taken beside a capacity write")
    `AST_CLK(a_result_follows, (s_tvalid && s_tready) |=> ##1 m_tvalid, "request gave no result")

endmodule

`default_nettype wire
